[hdl/cmm_pkg.sv]
// ----------------------------------------------------------------------------
// cmm_pkg
// Shared constants and controller/datapath interface types for the channel
// mixing matrix.
// ----------------------------------------------------------------------------
package cmm_pkg;

	// fixed source frame layout
	localparam int unsigned SOURCE_CHANNELS  = 12;
	localparam logic [3:0]  SRC_COUNT        = 4'd12;
	localparam logic [3:0]  LAST_SOURCE      = 4'd11;

	// default number of destination columns
	localparam int unsigned MAX_DEST_DEFAULT = 16;

	// field widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned GAIN_W   = 16;
	localparam int unsigned PROD_W   = SAMPLE_W + GAIN_W;
	// accumulator headroom well beyond a twelve-source frame
	localparam int unsigned ACC_W    = 48;
	localparam int unsigned FRAC_W   = 14;

	// dest_count register
	localparam logic [4:0] DEST_COUNT_RESET = 5'd16;

	// operation codes carried in tuser
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic take_item;
		logic load_gain;
		logic clear_write;
		logic d_clear;
		logic d_inc;
		logic mac_issue;
		logic out_load;
		logic acc_flush;
	} cmm_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic clear_done;
		logic src_ok;
		logic is_sample;
		logic dst_ok;
		logic src_last;
		logic d_at_end;
		logic pipe_busy;
		logic out_last;
	} cmm_sts_t;

endpackage

[hdl/cmm_ram.sv]
// ----------------------------------------------------------------------------
// cmm_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module cmm_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/cmm_ctrl.sv]
// ----------------------------------------------------------------------------
// cmm_ctrl
// Sequencer for the mixing matrix: gain memory clearing, gain loads,
// multiply-accumulate sweeps and per-destination result emission.
// ----------------------------------------------------------------------------
module cmm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  cmm_pkg::cmm_sts_t sts,
	output cmm_pkg::cmm_cmd_t cmd
);
	import cmm_pkg::*;

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_DECODE = 8'b0000_0100,
		S_MAC    = 8'b0000_1000,
		S_DRAIN  = 8'b0001_0000,
		S_RD     = 8'b0010_0000,
		S_FMT    = 8'b0100_0000,
		S_OUT    = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// handshake outputs
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_write = 1'b1;
				if (sts.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.take_item = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.d_clear = 1'b1;
				if (!sts.src_ok) begin
					state_d = S_IDLE;
				end else if (!sts.is_sample) begin
					cmd.load_gain = sts.dst_ok;
					state_d       = S_IDLE;
				end else begin
					state_d = S_MAC;
				end
			end
			S_MAC: begin
				cmd.mac_issue = 1'b1;
				cmd.d_inc     = 1'b1;
				if (sts.d_at_end) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) begin
					cmd.d_clear = 1'b1;
					state_d     = sts.src_last ? S_RD : S_IDLE;
				end
			end
			S_RD: begin
				state_d = S_FMT;
			end
			S_FMT: begin
				cmd.out_load = 1'b1;
				state_d      = S_OUT;
			end
			S_OUT: begin
				if (m_axis_tready) begin
					if (sts.out_last) begin
						cmd.acc_flush = 1'b1;
						state_d       = S_IDLE;
					end else begin
						cmd.d_inc = 1'b1;
						state_d   = S_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hdl/cmm_dpath.sv]
// ----------------------------------------------------------------------------
// cmm_dpath
// Datapath for the mixing matrix: request register, gain memory,
// accumulator memory with valid bits, two-stage multiply-accumulate pipe
// and the round/saturate output register.
// ----------------------------------------------------------------------------
module cmm_dpath #(
	parameter int unsigned MAX_DESTINATIONS = cmm_pkg::MAX_DEST_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cmm_pkg::cmm_cmd_t                 cmd,
	output cmm_pkg::cmm_sts_t                 sts,
	input  logic [4:0]                        dest_count,
	input  logic                              in_operation,
	input  logic [3:0]                        in_source_index,
	input  logic [3:0]                        in_dest_index,
	input  logic signed [cmm_pkg::GAIN_W-1:0]   in_gain,
	input  logic signed [cmm_pkg::SAMPLE_W-1:0] in_sample,
	output logic [3:0]                        out_channel,
	output logic signed [cmm_pkg::SAMPLE_W-1:0] mixed_sample,
	output logic                              clipped,
	output logic                              last
);
	import cmm_pkg::*;

	localparam int unsigned GAIN_DEPTH = SOURCE_CHANNELS * MAX_DESTINATIONS;
	localparam int unsigned GAW = (GAIN_DEPTH > 1) ? $clog2(GAIN_DEPTH) : 1;
	localparam int unsigned DW  = (MAX_DESTINATIONS > 1) ? $clog2(MAX_DESTINATIONS) : 1;
	localparam int unsigned CW  = ($clog2(MAX_DESTINATIONS + 1) > 5) ?
		$clog2(MAX_DESTINATIONS + 1) : 5;
	localparam int unsigned RW  = ACC_W - FRAC_W;
	localparam logic [DW-1:0]  D_LAST     = DW'(MAX_DESTINATIONS - 1);
	localparam logic [GAW-1:0] CLEAR_LAST = GAW'(GAIN_DEPTH - 1);

	// request register
	logic                       op_q;
	logic [3:0]                 src_q;
	logic [3:0]                 dst_q;
	logic signed [GAIN_W-1:0]   gain_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	// counters and valid bits
	logic [GAW-1:0]              clr_q;
	logic [DW-1:0]               d_q;
	logic [MAX_DESTINATIONS-1:0] vld_q;

	// memory ports
	logic                    gain_we;
	logic [GAW-1:0]          gain_waddr;
	logic [GAIN_W-1:0]       gain_wdata;
	logic [GAW-1:0]          gain_raddr;
	logic [GAIN_W-1:0]       gain_rd;
	logic [ACC_W-1:0]        acc_rd;
	logic signed [ACC_W-1:0] acc_sum;

	// mac pipe
	logic                    mac_s1;
	logic                    hit_s1;
	logic [DW-1:0]           d_s1;
	logic                    mac_s2;
	logic [DW-1:0]           d_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_s2;

	// emit path
	logic [CW-1:0]           cnt;
	logic signed [ACC_W-1:0] emit_acc;
	logic signed [ACC_W-1:0] emit_rnd;
	logic signed [RW-1:0]    emit_r;
	logic                    emit_clip;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			op_q     <= in_operation;
			src_q    <= in_source_index;
			dst_q    <= in_dest_index;
			gain_q   <= in_gain;
			sample_q <= in_sample;
		end
	end

	// clear sweep counter and destination counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			d_q   <= '0;
		end else begin
			if (cmd.clear_write) begin
				clr_q <= clr_q + GAW'(1);
			end
			if (cmd.d_clear) begin
				d_q <= '0;
			end else if (cmd.d_inc) begin
				d_q <= d_q + DW'(1);
			end
		end
	end

	// gain memory: clearing sweep or one gain load, read along the source row
	assign gain_we    = cmd.clear_write | cmd.load_gain;
	assign gain_waddr = cmd.clear_write ? clr_q : GAW'(src_q * MAX_DESTINATIONS + dst_q);
	assign gain_wdata = cmd.clear_write ? '0 : gain_q;
	assign gain_raddr = GAW'(src_q * MAX_DESTINATIONS + d_q);

	cmm_ram #(
		.WIDTH (GAIN_W),
		.DEPTH (GAIN_DEPTH),
		.AW    (GAW)
	) u_gain_ram (
		.clk   (clk),
		.we    (gain_we),
		.waddr (gain_waddr),
		.wdata (gain_wdata),
		.raddr (gain_raddr),
		.rdata (gain_rd)
	);

	// accumulator memory, written back from the second mac stage
	cmm_ram #(
		.WIDTH (ACC_W),
		.DEPTH (MAX_DESTINATIONS),
		.AW    (DW)
	) u_acc_ram (
		.clk   (clk),
		.we    (mac_s2),
		.waddr (d_s2),
		.wdata (acc_sum),
		.raddr (d_q),
		.rdata (acc_rd)
	);

	// pipe control and accumulator valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= 1'b0;
			mac_s2 <= 1'b0;
			vld_q  <= '0;
		end else begin
			mac_s1 <= cmd.mac_issue;
			mac_s2 <= mac_s1;
			if (cmd.acc_flush) begin
				vld_q <= '0;
			end else if (mac_s2) begin
				vld_q[d_s2] <= 1'b1;
			end
		end
	end

	// pipe payload: multiply in stage one, add in stage two
	always_ff @(posedge clk) begin
		hit_s1  <= vld_q[d_q];
		d_s1    <= d_q;
		d_s2    <= d_s1;
		prod_s2 <= sample_q * $signed(gain_rd);
		acc_s2  <= hit_s1 ? $signed(acc_rd) : '0;
	end

	assign acc_sum = acc_s2 + ACC_W'(prod_s2);

	// destination count clamped to 1..MAX_DESTINATIONS
	always_comb begin
		if (dest_count == 5'd0) begin
			cnt = CW'(1);
		end else if (int'(dest_count) > MAX_DESTINATIONS) begin
			cnt = CW'(MAX_DESTINATIONS);
		end else begin
			cnt = CW'(dest_count);
		end
	end

	// round half away from zero at bit 14, then saturate to int16
	assign emit_acc  = hit_s1 ? $signed(acc_rd) : '0;
	assign emit_rnd  = emit_acc + (emit_acc[ACC_W-1] ? ACC_W'(8191) : ACC_W'(8192));
	assign emit_r    = emit_rnd[ACC_W-1:FRAC_W];
	assign emit_clip = !((&emit_r[RW-1:SAMPLE_W-1]) || !(|emit_r[RW-1:SAMPLE_W-1]));

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_channel <= 4'(d_q);
			clipped     <= emit_clip;
			last        <= (CW'(d_q) == cnt - CW'(1));
			if (emit_clip) begin
				mixed_sample <= emit_r[RW-1] ? 16'sh8000 : 16'sh7fff;
			end else begin
				mixed_sample <= emit_r[SAMPLE_W-1:0];
			end
		end
	end

	// status
	assign sts.clear_done = (clr_q == CLEAR_LAST);
	assign sts.src_ok     = (src_q < SRC_COUNT);
	assign sts.is_sample  = (op_q == OP_SAMPLE);
	assign sts.dst_ok     = (int'(dst_q) < MAX_DESTINATIONS);
	assign sts.src_last   = (src_q == LAST_SOURCE);
	assign sts.d_at_end   = (d_q == D_LAST);
	assign sts.pipe_busy  = mac_s1 | mac_s2;
	assign sts.out_last   = (CW'(d_q) == cnt - CW'(1));

endmodule

[hdl/channel_mixing_matrix.sv]
// ----------------------------------------------------------------------------
// channel_mixing_matrix
// Mixes frames of twelve signed 16-bit source samples into up to
// MAX_DESTINATIONS outputs through a stored Q2.14 gain matrix.
// ----------------------------------------------------------------------------
// After reset the gain memory is zeroed by a sweep over its
// 12*MAX_DESTINATIONS entries (192 at the default) during which no request is
// taken; dest_count writes are taken throughout. A gain load is written from
// the decode state. A sample feeds one gain memory read per destination into a
// two-stage multiply and accumulate pipe, which drains before the next
// request. The sample for source 11 then emits one result per destination in
// use through the read, format and output states, held under backpressure,
// and clears all accumulators when the last result is taken.
module channel_mixing_matrix #(
	parameter int unsigned MAX_DESTINATIONS = cmm_pkg::MAX_DEST_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,       // dest_count
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,    // source_index, dest_index, gain, sample
	input  logic [0:0]  s_axis_tuser,    // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,    // out_channel, mixed_sample, zero pad
	output logic [0:0]  m_axis_tuser,    // clipped
	output logic        m_axis_tlast     // last
);
	import cmm_pkg::*;

	cmm_cmd_t                   cmd;
	cmm_sts_t                   sts;
	logic [4:0]                 dest_count_q;
	logic [3:0]                 out_channel;
	logic signed [SAMPLE_W-1:0] mixed_sample;
	logic                       clipped;
	logic                       last;

	// destination count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_count_q <= DEST_COUNT_RESET;
		end else if (cfg_we) begin
			dest_count_q <= cfg_wdata;
		end
	end

	cmm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	cmm_dpath #(
		.MAX_DESTINATIONS (MAX_DESTINATIONS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.dest_count      (dest_count_q),
		.in_operation    (s_axis_tuser[0]),
		.in_source_index (s_axis_tdata[3:0]),
		.in_dest_index   (s_axis_tdata[7:4]),
		.in_gain         (s_axis_tdata[23:8]),
		.in_sample       (s_axis_tdata[39:24]),
		.out_channel     (out_channel),
		.mixed_sample    (mixed_sample),
		.clipped         (clipped),
		.last            (last)
	);

	// output packing
	assign m_axis_tdata = {4'b0000, mixed_sample, out_channel};
	assign m_axis_tuser = clipped;
	assign m_axis_tlast = last;

`ifndef ASSERT_OFF
	// requests are never taken while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("request taken while result pending");

	// the block is ready again right after the last result of a frame
	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
		else $error("not ready after frame end");

	// a non-final result is followed by the next destination
	a_next_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> ##2
		(m_axis_tvalid && (m_axis_tdata[3:0] == $past(m_axis_tdata[3:0], 3) + 4'd1)))
		else $error("destination sequence broken");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// channel_mixing_matrix testbench
// Drives gain loads and source samples into the mixer over the request
// stream. A behavioral mixer inside the bench predicts every output sample.
// The bench compares each output beat, field by field, against the oldest
// prediction. Both stream sides idle at random, except in the final frames.
// ----------------------------------------------------------------------------
module testbench;

	import cmm_pkg::*;

	localparam int unsigned NUM_DEST      = MAX_DEST_DEFAULT;
	localparam int          SETTLE_CYCLES = 40;
	localparam int          HANG_LIMIT    = 2000;
	localparam int          RANDOM_ITEMS  = 60;

	typedef struct {
		logic [3:0]  channel;
		logic [15:0] level;
		logic        clipped;
		logic        last;
	} mix_result_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [4:0]  cfg_wdata     = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata  = '0;    // source_index, dest_index, gain, sample
	logic [0:0]  s_axis_tuser  = '0;    // operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;          // out_channel, mixed_sample, zero pad
	logic [0:0]  m_axis_tuser;          // clipped
	logic        m_axis_tlast;          // last

	// behavioral mixer state
	shortint     gain_matrix [SOURCE_CHANNELS][NUM_DEST];
	longint      dest_sum [NUM_DEST];
	logic [4:0]  dest_count_reg = DEST_COUNT_RESET;
	mix_result_t expected_mix [$];

	int error_count = 0;
	int items_sent  = 0;
	int idle_cycles = 0;
	bit idle_on     = 1'b1;
	int stall_left  = 0;

	channel_mixing_matrix DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// mixer prediction for one accepted request
	function automatic void predict_request(input logic op, input logic [3:0] src,
			input logic [3:0] dst, input logic signed [15:0] g, input logic signed [15:0] s);
		int          count;
		bit          neg;
		longint      mag;
		longint      rounded;
		longint      level;
		mix_result_t res;
		if (src >= SOURCE_CHANNELS) return;
		if (op == OP_LOAD) begin
			gain_matrix[src][dst] = g;
			return;
		end
		for (int d = 0; d < NUM_DEST; d++)
			dest_sum[d] += longint'(s) * longint'(gain_matrix[src][d]);
		if (src != LAST_SOURCE) return;
		count = dest_count_reg;
		if (count < 1) count = 1;
		if (count > NUM_DEST) count = NUM_DEST;
		for (int d = 0; d < count; d++) begin
			// round half away from zero at bit 14, then saturate
			neg = dest_sum[d] < 0;
			mag = neg ? -dest_sum[d] : dest_sum[d];
			rounded = (mag + 8192) >>> 14;
			res.clipped = 1'b0;
			if (neg) begin
				if (rounded > 32768) begin
					res.clipped = 1'b1;
					level = -32768;
				end else begin
					level = -rounded;
				end
			end else begin
				if (rounded > 32767) begin
					res.clipped = 1'b1;
					level = 32767;
				end else begin
					level = rounded;
				end
			end
			res.channel = d[3:0];
			res.level   = level[15:0];
			res.last    = (d + 1 == count);
			expected_mix.insert(expected_mix.size(), res);
		end
		for (int d = 0; d < NUM_DEST; d++)
			dest_sum[d] = 0;
	endfunction

	// send one request, optionally after a short idle burst
	task automatic send_request(input logic op, input logic [3:0] src, input logic [3:0] dst,
			input logic [15:0] g, input logic [15:0] s);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {s, g, dst, src};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		predict_request(op, src, dst, g, s);
		if (src < SOURCE_CHANNELS) items_sent++;
	endtask

	task automatic release_bus();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic drain_results();
		while (expected_mix.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// dest_count write while the mixer is idle
	task automatic write_dest_count(input logic [4:0] value);
		release_bus();
		drain_results();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		dest_count_reg = value;
	endtask

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 5))
			0:       return 16'($urandom_range(0, 4096)) - 16'd2048;
			1:       return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
			2:       return 16'd0;
			3:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			1:       return 16'($urandom_range(0, 512)) - 16'd256;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [4:0] pick_count();
		case ($urandom_range(0, 5))
			0:       return 5'd0;
			1:       return 5'd1;
			2:       return 5'd16;
			3:       return 5'd31;
			default: return 5'($urandom_range(0, 31));
		endcase
	endfunction

	// one frame: random gain loads, occasional noise, then the source samples, in order unless broken
	task automatic send_frame(input bit broken);
		int          loads;
		int          length;
		logic [3:0]  src;
		loads = $urandom_range(0, 6);
		for (int i = 0; i < loads; i++)
			send_request(OP_LOAD, 4'($urandom_range(0, SOURCE_CHANNELS - 1)),
				4'($urandom_range(0, 15)), pick_gain(), 16'($urandom()));
		// occasional noise: a request on a source that does not exist
		if ($urandom_range(0, 4) == 0)
			send_request(1'($urandom_range(0, 1)), 4'($urandom_range(12, 15)),
				4'($urandom_range(0, 15)), 16'($urandom()), 16'($urandom()));
		if (!broken) begin
			for (int i = 0; i < SOURCE_CHANNELS; i++)
				send_request(OP_SAMPLE, 4'(i), 4'($urandom_range(0, 15)),
					16'($urandom()), pick_sample());
		end else begin
			// sources skipped, repeated or out of order, then the close
			length = $urandom_range(1, 14);
			for (int i = 0; i < length; i++) begin
				src = 4'($urandom_range(0, 15));
				if (src == LAST_SOURCE) src = 4'd0;
				send_request(OP_SAMPLE, src, 4'($urandom_range(0, 15)),
					16'($urandom()), pick_sample());
			end
			send_request(OP_SAMPLE, LAST_SOURCE, 4'($urandom_range(0, 15)),
				16'($urandom()), pick_sample());
		end
	endtask

	// all-zero gains after reset, default count, lone closing sample
	task automatic test_reset_state();
		send_request(OP_SAMPLE, LAST_SOURCE, 4'd0, 16'd0, 16'h7fff);
	endtask

	// full-scale gains and samples, clipping in both directions
	task automatic test_gain_extremes();
		write_dest_count(5'd4);
		send_request(OP_LOAD, LAST_SOURCE, 4'd0, 16'h7fff, 16'd0);
		send_request(OP_LOAD, LAST_SOURCE, 4'd1, 16'h8000, 16'd0);
		send_request(OP_LOAD, LAST_SOURCE, 4'd2, 16'h4000, 16'd0);
		send_request(OP_LOAD, LAST_SOURCE, 4'd3, 16'h0001, 16'd0);
		send_request(OP_SAMPLE, LAST_SOURCE, 4'd0, 16'd0, 16'h8000);
		send_request(OP_SAMPLE, LAST_SOURCE, 4'd15, 16'hffff, 16'h7fff);
	endtask

	// half-way rounding, and requests on sources that do not exist
	task automatic test_rounding_and_ignored();
		send_request(OP_LOAD, 4'd12, 4'd0, 16'h4000, 16'd0);
		send_request(OP_LOAD, 4'd15, 4'd15, 16'hffff, 16'hffff);
		send_request(OP_SAMPLE, 4'd15, 4'd0, 16'd0, 16'h7fff);
		send_request(OP_SAMPLE, 4'd13, 4'd0, 16'd0, 16'h8000);
		send_request(OP_SAMPLE, LAST_SOURCE, 4'd0, 16'd0, 16'd8192);
		send_request(OP_SAMPLE, LAST_SOURCE, 4'd0, 16'd0, -16'sd8192);
	endtask

	// repeated and missing sources, count of zero and above range mid-frame
	task automatic test_order_and_count();
		send_request(OP_LOAD, 4'd3, 4'd0, 16'h4000, 16'd0);
		send_request(OP_SAMPLE, 4'd3, 4'd0, 16'd0, 16'd100);
		send_request(OP_SAMPLE, 4'd3, 4'd0, 16'd0, 16'd100);
		write_dest_count(5'd0);
		send_request(OP_SAMPLE, LAST_SOURCE, 4'd0, 16'd0, 16'd0);
		send_request(OP_SAMPLE, 4'd5, 4'd0, 16'd0, 16'hffff);
		write_dest_count(5'd31);
		send_request(OP_SAMPLE, LAST_SOURCE, 4'd0, 16'd0, 16'd1);
	endtask

	// random frames with count changes between them
	task automatic test_random_frames();
		int start;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0) write_dest_count(pick_count());
			send_frame($urandom_range(0, 5) == 0);
		end
	endtask

	// closing frames with both sides always ready
	task automatic test_unstalled_tail();
		write_dest_count(5'd16);
		idle_on = 1'b0;
		send_frame(1'b0);
		send_frame(1'b0);
	endtask

	// output side: random stall bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left    <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left    <= $urandom_range(0, 3);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// compare each output beat with the oldest prediction
	always @(posedge clk) begin : check_results
		mix_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_mix.size() == 0) begin
				$error("unexpected result on channel %0d", m_axis_tdata[3:0]);
				error_count++;
			end else begin
				want = expected_mix.pop_front();
				if (m_axis_tdata[3:0] !== want.channel) begin
					$error("out_channel: expected %0d, got %0d", want.channel, m_axis_tdata[3:0]);
					error_count++;
				end
				if (m_axis_tdata[19:4] !== want.level) begin
					$error("mixed_sample: expected %0d, got %0d",
						$signed(want.level), $signed(m_axis_tdata[19:4]));
					error_count++;
				end
				if (m_axis_tuser[0] !== want.clipped) begin
					$error("clipped: expected %0b, got %0b", want.clipped, m_axis_tuser[0]);
					error_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, m_axis_tlast);
					error_count++;
				end
			end
		end
	end

	// hang detection: cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("channel_mixing_matrix regression: fail");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < SOURCE_CHANNELS; i++)
			for (int d = 0; d < NUM_DEST; d++)
				gain_matrix[i][d] = 0;
		for (int d = 0; d < NUM_DEST; d++)
			dest_sum[d] = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_gain_extremes();
		test_rounding_and_ignored();
		test_order_and_count();
		test_random_frames();
		test_unstalled_tail();

		release_bus();
		drain_results();
		if (error_count == 0)
			$display("channel_mixing_matrix regression: pass");
		else
			$display("channel_mixing_matrix regression: fail");
		$finish;
	end

endmodule
